[rtl/core/apsp_pkg.sv]
// shared codes and types for the all-pairs shortest path block
package apsp_pkg;

   localparam int NODES_DEF       = 16;
   localparam int DIST_BITS_DEF   = 48;
   localparam int WEIGHT_BITS_DEF = 32;

   localparam logic [6:0] NODE_COUNT_RESET = 7'd16;

   // request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_PAIR = 2'd2;
   localparam logic [1:0] MODE_PATH = 2'd3;

   // entry classes, also used as response status
   localparam logic [1:0] CLS_FIN  = 2'd0;
   localparam logic [1:0] CLS_NONE = 2'd1;
   localparam logic [1:0] CLS_NEG  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   typedef struct packed {
      logic [1:0] ik_cls;
      logic [1:0] kj_cls;
      logic [1:0] ij_cls;
      logic       neg_sweep;
   } relax_ctl_type;

endpackage

[rtl/core/all_pairs_shortest_path_top.sv]
// all-pairs shortest path engine with negative cycle marking, top level
//
//  channel | direction | handshake          | word
//  req_    | in        | req_valid/req_stall | mode, row, col, weight, has_edge
//  rsp_    | out       | rsp_valid/rsp_stall | status, distance, next_node, path_node, last
//  csr_    | in        | csr_valid/csr_ready | node_count
//
// a load is written to the adjacency store as it is accepted; a pair query reads
// the table and sends one word; a path query first walks the hops to check them,
// then emits one word per node; a run seeds the table, then makes a relaxation and a
// negative cycle sweep; each relaxation is a read, sum and write of the table memory
// reset is synchronous and acts on control only, setting the node count to 16; table
// contents are undefined until a run writes them
// a stalled response holds the engine at its next word; req_stall is high
// whenever an item is in progress
module all_pairs_shortest_path_top #(
   parameter int NODES       = apsp_pkg::NODES_DEF,
   parameter int DIST_BITS   = apsp_pkg::DIST_BITS_DEF,
   parameter int WEIGHT_BITS = apsp_pkg::WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic signed [31:0] req_weight,
   input  logic               req_has_edge,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [47:0] rsp_distance,
   output logic [5:0]         rsp_next_node,
   output logic [5:0]         rsp_path_node,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data
);

   localparam int NB = $clog2(NODES);     // node index bits
   localparam int CW = NB + 1;            // node count bits
   localparam int AW = 2 * NB;            // table address bits
   localparam int EW = 2 + DIST_BITS + NB; // class, distance, next hop
   localparam int JW = 1 + DIST_BITS;     // edge bit, weight

   localparam logic signed [63:0] WMAX = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
   localparam logic signed [63:0] DMAX = (64'sd1 <<< (DIST_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] DMIN = -DMAX - 64'sd1;
   localparam logic signed [63:0] LIM_HI = (WMAX < DMAX) ? WMAX : DMAX;
   localparam logic signed [63:0] LIM_LO = (WMIN > DMIN) ? WMIN : DMIN;

   typedef enum logic [3:0] {
      IDLE, CP_RD, CP_WR, RX_IK, RX_IKW, RX_RD, RX_SUM, RX_WR,
      Q_RD, Q_CHK, W1_RD, W1_CHK, W2_TOP, W2_RD, W2_CHK, SEND
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [6:0]    node_count_ff, node_count_in;
   logic          computed_ff, computed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          neg_sweep_ff, neg_sweep_in;
   // loop and walk registers
   logic [NB-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [NB-1:0] r_ff, r_in, c_ff, c_in, curr_ff, curr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    mode_ff, mode_in;
   logic [EW-1:0] ik_ff, ik_in;
   logic signed [DIST_BITS-1:0] xdist_ff, xdist_in;
   logic [NB-1:0] xnh_ff, xnh_in;
   // word waiting for the output register
   logic [1:0]    pend_status_ff, pend_status_in;
   logic [NB-1:0] pend_path_ff, pend_path_in;
   logic          pend_last_ff, pend_last_in;
   // output payload
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [47:0] rsp_distance_ff, rsp_distance_in;
   logic [5:0]         rsp_next_ff, rsp_next_in;
   logic [5:0]         rsp_path_ff, rsp_path_in;
   logic               rsp_last_ff, rsp_last_in;

   // memory strobes
   logic          adj_we, adj_re;
   logic [AW-1:0] adj_waddr, adj_raddr;
   logic [JW-1:0] adj_wdata, adj_rdata;
   logic          tab_we, tab_re_a, tab_re_b;
   logic [AW-1:0] tab_waddr, tab_raddr_a, tab_raddr_b;
   logic [EW-1:0] tab_wdata, tab_rdata_a, tab_rdata_b;

   logic [CW-1:0] n_use, n_last;
   logic          out_free, accept;
   logic signed [63:0] w_ext, w_clamp;
   logic          relax_upd, sum_en;
   logic signed [DIST_BITS-1:0] relax_sum;
   apsp_pkg::relax_ctl_type relax_ctl;

   // table word fields
   logic [1:0]    a_cls, ik_cls;
   logic [NB-1:0] a_nh, ik_nh;
   logic signed [DIST_BITS-1:0] a_dist, b_dist, ik_dist;

   assign a_cls   = tab_rdata_a[EW-1 -: 2];
   assign a_dist  = tab_rdata_a[NB +: DIST_BITS];
   assign a_nh    = tab_rdata_a[NB-1:0];
   assign b_dist  = tab_rdata_b[NB +: DIST_BITS];
   assign ik_cls  = ik_ff[EW-1 -: 2];
   assign ik_dist = ik_ff[NB +: DIST_BITS];
   assign ik_nh   = ik_ff[NB-1:0];

   // nodes in use: zero acts as one, above the array size acts as the size
   always_comb begin
      if (node_count_ff == 7'd0) begin
         n_use = CW'(1);
      end else if (node_count_ff > 7'(NODES)) begin
         n_use = CW'(NODES);
      end else begin
         n_use = node_count_ff[CW-1:0];
      end
   end
   assign n_last = n_use - CW'(1);

   // edge weight clipped to the weight and distance ranges
   assign w_ext = 64'(req_weight);
   always_comb begin
      if (w_ext > LIM_HI) begin
         w_clamp = LIM_HI;
      end else if (w_ext < LIM_LO) begin
         w_clamp = LIM_LO;
      end else begin
         w_clamp = w_ext;
      end
   end

   assign accept   = req_valid && (state_ff == IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign relax_ctl.ik_cls    = ik_cls;
   assign relax_ctl.kj_cls    = a_cls;
   assign relax_ctl.ij_cls    = tab_rdata_b[EW-1 -: 2];
   assign relax_ctl.neg_sweep = neg_sweep_ff;

   always_comb begin
      state_in       = state_ff;
      node_count_in  = node_count_ff;
      computed_in    = computed_ff;
      rsp_valid_in   = rsp_valid_ff;
      neg_sweep_in   = neg_sweep_ff;
      k_in = k_ff;  i_in = i_ff;  j_in = j_ff;
      r_in = r_ff;  c_in = c_ff;  curr_in = curr_ff;
      cnt_in         = cnt_ff;
      mode_in        = mode_ff;
      ik_in          = ik_ff;
      xdist_in       = xdist_ff;
      xnh_in         = xnh_ff;
      pend_status_in = pend_status_ff;
      pend_path_in   = pend_path_ff;
      pend_last_in   = pend_last_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_next_in     = rsp_next_ff;
      rsp_path_in     = rsp_path_ff;
      rsp_last_in     = rsp_last_ff;
      adj_we = 1'b0;  adj_re = 1'b0;
      adj_waddr = {req_row[NB-1:0], req_col[NB-1:0]};
      adj_wdata = {req_has_edge, w_clamp[DIST_BITS-1:0]};
      adj_raddr = {i_ff, j_ff};
      tab_we = 1'b0;  tab_re_a = 1'b0;  tab_re_b = 1'b0;
      tab_waddr   = {i_ff, j_ff};
      tab_wdata   = '0;
      tab_raddr_a = {r_ff, c_ff};
      tab_raddr_b = {i_ff, j_ff};
      sum_en = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register write: the user must write only while idle; the block does not enforce it
      if (csr_valid) begin
         node_count_in = csr_data;
         computed_in   = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               r_in    = req_row[NB-1:0];
               c_in    = req_col[NB-1:0];
               mode_in = req_mode;
               case (req_mode)
                  apsp_pkg::MODE_LOAD: begin
                     computed_in = 1'b0;
                     if ((7'(req_row) < 7'(NODES)) && (7'(req_col) < 7'(NODES))) begin
                        adj_we = 1'b1;
                     end
                  end
                  apsp_pkg::MODE_RUN: begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = CP_RD;
                  end
                  default: begin
                     if (!computed_ff || (7'(req_row) >= 7'(n_use))
                         || (7'(req_col) >= 7'(n_use))) begin
                        pend_status_in = apsp_pkg::CLS_NONE;
                        pend_path_in   = '0;
                        pend_last_in   = 1'b1;
                        state_in       = SEND;
                     end else begin
                        state_in = Q_RD;
                     end
                  end
               endcase
            end
         end
         // seed the table from the adjacency store
         CP_RD: begin
            adj_re   = 1'b1;
            state_in = CP_WR;
         end
         CP_WR: begin
            tab_we    = 1'b1;
            tab_wdata = adj_rdata[JW-1]
                        ? {apsp_pkg::CLS_FIN, adj_rdata[DIST_BITS-1:0], j_ff}
                        : {apsp_pkg::CLS_NONE, {DIST_BITS{1'b0}}, j_ff};
            state_in  = CP_RD;
            if (CW'(j_ff) == n_last) begin
               j_in = '0;
               if (CW'(i_ff) == n_last) begin
                  i_in         = '0;
                  k_in         = '0;
                  neg_sweep_in = 1'b0;
                  state_in     = RX_IK;
               end else begin
                  i_in = i_ff + NB'(1);
               end
            end else begin
               j_in = j_ff + NB'(1);
            end
         end
         // fetch d[i][k], held for the whole row
         RX_IK: begin
            tab_re_a    = 1'b1;
            tab_raddr_a = {i_ff, k_ff};
            state_in    = RX_IKW;
         end
         RX_IKW: begin
            ik_in    = tab_rdata_a;
            j_in     = '0;
            state_in = RX_RD;
         end
         RX_RD: begin
            tab_re_a    = 1'b1;
            tab_raddr_a = {k_ff, j_ff};
            tab_re_b    = 1'b1;
            tab_raddr_b = {i_ff, j_ff};
            state_in    = RX_SUM;
         end
         RX_SUM: begin
            sum_en   = 1'b1;
            state_in = RX_WR;
         end
         RX_WR: begin
            tab_wdata = neg_sweep_ff
                        ? {apsp_pkg::CLS_NEG, {DIST_BITS{1'b0}}, {NB{1'b0}}}
                        : {apsp_pkg::CLS_FIN, relax_sum, ik_nh};
            if (relax_upd) begin
               tab_we = 1'b1;
               // writing d[i][k] itself: the held copy follows
               if (j_ff == k_ff) begin
                  ik_in = tab_wdata;
               end
            end
            state_in = RX_RD;
            if (CW'(j_ff) == n_last) begin
               state_in = RX_IK;
               if (CW'(i_ff) == n_last) begin
                  i_in = '0;
                  if (CW'(k_ff) == n_last) begin
                     k_in = '0;
                     if (neg_sweep_ff) begin
                        computed_in    = 1'b1;
                        pend_status_in = apsp_pkg::ST_DONE;
                        pend_path_in   = '0;
                        pend_last_in   = 1'b1;
                        state_in       = SEND;
                     end else begin
                        neg_sweep_in = 1'b1;
                     end
                  end else begin
                     k_in = k_ff + NB'(1);
                  end
               end else begin
                  i_in = i_ff + NB'(1);
               end
            end else begin
               j_in = j_ff + NB'(1);
            end
         end
         Q_RD: begin
            tab_re_a = 1'b1;
            state_in = Q_CHK;
         end
         Q_CHK: begin
            xdist_in     = a_dist;
            xnh_in       = a_nh;
            pend_path_in = '0;
            pend_last_in = 1'b1;
            if (a_cls != apsp_pkg::CLS_FIN) begin
               pend_status_in = a_cls;
               state_in       = SEND;
            end else if (mode_ff == apsp_pkg::MODE_PAIR) begin
               pend_status_in = apsp_pkg::CLS_FIN;
               state_in       = SEND;
            end else begin
               curr_in  = r_ff;
               cnt_in   = '0;
               state_in = W1_RD;
            end
         end
         // check walk: every hop must be finite, the walk short enough and d[c][c] not negative
         W1_RD: begin
            tab_re_a    = 1'b1;
            tab_raddr_a = (curr_ff == c_ff) ? {c_ff, c_ff} : {curr_ff, c_ff};
            state_in    = W1_CHK;
         end
         W1_CHK: begin
            pend_path_in = '0;
            pend_last_in = 1'b1;
            if (curr_ff == c_ff) begin
               if (a_cls == apsp_pkg::CLS_NEG) begin
                  pend_status_in = apsp_pkg::CLS_NEG;
                  state_in       = SEND;
               end else begin
                  curr_in  = r_ff;
                  state_in = W2_TOP;
               end
            end else if ((a_cls != apsp_pkg::CLS_FIN) || (cnt_ff == n_last)) begin
               pend_status_in = (a_cls == apsp_pkg::CLS_NONE) ? apsp_pkg::CLS_NONE
                                                              : apsp_pkg::CLS_NEG;
               state_in       = SEND;
            end else begin
               cnt_in  = cnt_ff + CW'(1);
               curr_in = a_nh;
               if (CW'(a_nh) >= n_use) begin
                  pend_status_in = apsp_pkg::CLS_NEG;
                  state_in       = SEND;
               end else begin
                  state_in = W1_RD;
               end
            end
         end
         // emitting walk, one node per word
         W2_TOP: begin
            pend_status_in = apsp_pkg::CLS_FIN;
            pend_path_in   = curr_ff;
            pend_last_in   = (curr_ff == c_ff);
            state_in       = SEND;
         end
         W2_RD: begin
            tab_re_a    = 1'b1;
            tab_raddr_a = {curr_ff, c_ff};
            state_in    = W2_CHK;
         end
         W2_CHK: begin
            curr_in  = a_nh;
            state_in = W2_TOP;
         end
         SEND: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = pend_status_ff;
               rsp_distance_in = (pend_status_ff == apsp_pkg::CLS_FIN)
                                 ? 48'(64'(xdist_ff)) : 48'sd0;
               rsp_next_in     = (pend_status_ff == apsp_pkg::CLS_FIN) ? 6'(xnh_ff) : 6'd0;
               rsp_path_in     = 6'(pend_path_ff);
               rsp_last_in     = pend_last_ff;
               state_in        = pend_last_ff ? IDLE : W2_RD;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         node_count_ff <= apsp_pkg::NODE_COUNT_RESET;
         computed_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         computed_ff   <= computed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      neg_sweep_ff    <= neg_sweep_in;
      k_ff <= k_in;  i_ff <= i_in;  j_ff <= j_in;
      r_ff <= r_in;  c_ff <= c_in;  curr_ff <= curr_in;
      cnt_ff          <= cnt_in;
      mode_ff         <= mode_in;
      ik_ff           <= ik_in;
      xdist_ff        <= xdist_in;
      xnh_ff          <= xnh_in;
      pend_status_ff  <= pend_status_in;
      pend_path_ff    <= pend_path_in;
      pend_last_ff    <= pend_last_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_next_ff     <= rsp_next_in;
      rsp_path_ff     <= rsp_path_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // adjacency store: edge bit and clipped weight
   apsp_ram #(
      .WIDTH     (JW),
      .ADDR_BITS (AW)
   ) u_adj_ram (
      .clock   (clock),
      .we      (adj_we),
      .waddr   (adj_waddr),
      .wdata   (adj_wdata),
      .re_a    (adj_re),
      .raddr_a (adj_raddr),
      .rdata_a (adj_rdata),
      .re_b    (1'b0),
      .raddr_b ({AW{1'b0}}),
      .rdata_b ()
   );

   // distance table: class, distance and first hop per pair
   apsp_ram #(
      .WIDTH     (EW),
      .ADDR_BITS (AW)
   ) u_tab_ram (
      .clock   (clock),
      .we      (tab_we),
      .waddr   (tab_waddr),
      .wdata   (tab_wdata),
      .re_a    (tab_re_a),
      .raddr_a (tab_raddr_a),
      .rdata_a (tab_rdata_a),
      .re_b    (tab_re_b),
      .raddr_b (tab_raddr_b),
      .rdata_b (tab_rdata_b)
   );

   apsp_relax #(
      .DIST_BITS (DIST_BITS)
   ) u_relax (
      .clock   (clock),
      .sum_en  (sum_en),
      .ctl     (relax_ctl),
      .ik_dist (ik_dist),
      .kj_dist (a_dist),
      .ij_dist (b_dist),
      .update  (relax_upd),
      .sum     (relax_sum)
   );

   assign req_stall     = (state_ff != IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_next_node = rsp_next_ff;
   assign rsp_path_node = rsp_path_ff;
   assign rsp_last      = rsp_last_ff;

   // a done word is always the only word of its run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == apsp_pkg::ST_DONE) |-> rsp_last)
      else $error("run done word without last");

   // the table is written only by the seeding pass and the relaxation sweeps
   a_tab_write: assert property (@(posedge clock) disable iff (reset)
      tab_we |-> (state_ff == CP_WR) || (state_ff == RX_WR))
      else $error("table write outside a run");

   // failure and done words carry no distance, hop or node
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != apsp_pkg::CLS_FIN)
      |-> (rsp_distance == 48'sd0) && (rsp_next_node == 6'd0) && (rsp_path_node == 6'd0))
      else $error("non-finite word with payload");

   // loading an edge invalidates earlier results
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      adj_we |=> !computed_ff)
      else $error("results still marked valid after a load");

endmodule

[rtl/core/apsp_ram.sv]
// synchronous ram, one write port and two registered read ports
module apsp_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re_a,
   input  logic [ADDR_BITS-1:0] raddr_a,
   output logic [WIDTH-1:0]     rdata_a,
   input  logic                 re_b,
   input  logic [ADDR_BITS-1:0] raddr_b,
   output logic [WIDTH-1:0]     rdata_b
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re_a) begin
         rdata_a_ff <= mem_ff[raddr_a];
      end
      if (re_b) begin
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[rtl/core/apsp_relax.sv]
// saturating min-plus relaxation step with registered sum
module apsp_relax #(
   parameter int DIST_BITS = apsp_pkg::DIST_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        sum_en,
   input  apsp_pkg::relax_ctl_type     ctl,
   input  logic signed [DIST_BITS-1:0] ik_dist,
   input  logic signed [DIST_BITS-1:0] kj_dist,
   input  logic signed [DIST_BITS-1:0] ij_dist,
   output logic                        update,
   output logic signed [DIST_BITS-1:0] sum
);

   logic signed [DIST_BITS:0]   full;
   logic signed [DIST_BITS-1:0] sum_in;
   logic signed [DIST_BITS-1:0] sum_ff;
   logic                        lt;

   assign full = (DIST_BITS+1)'(ik_dist) + (DIST_BITS+1)'(kj_dist);

   // clip to the stored range on overflow
   always_comb begin
      if (full[DIST_BITS] != full[DIST_BITS-1]) begin
         sum_in = full[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}}
                                  : {1'b0, {(DIST_BITS-1){1'b1}}};
      end else begin
         sum_in = full[DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign lt  = sum_ff < ij_dist;
   assign sum = sum_ff;

   always_comb begin
      if (!ctl.neg_sweep) begin
         update = (ctl.ik_cls == apsp_pkg::CLS_FIN) && (ctl.kj_cls == apsp_pkg::CLS_FIN)
                  && ((ctl.ij_cls == apsp_pkg::CLS_NONE) || lt);
      end else begin
         update = (ctl.ik_cls != apsp_pkg::CLS_NONE) && (ctl.kj_cls != apsp_pkg::CLS_NONE)
                  && (ctl.ij_cls != apsp_pkg::CLS_NEG)
                  && ((ctl.ik_cls == apsp_pkg::CLS_NEG) || (ctl.kj_cls == apsp_pkg::CLS_NEG)
                      || (ctl.ij_cls == apsp_pkg::CLS_NONE) || lt);
      end
   end

endmodule

[dv/all_pairs_shortest_path_checker.sv]
// watches the request, response and csr channels, predicts every response word and compares
module all_pairs_shortest_path_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic signed [31:0] req_weight,
   input  logic               req_has_edge,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic signed [47:0] rsp_distance,
   input  logic [5:0]         rsp_next_node,
   input  logic [5:0]         rsp_path_node,
   input  logic               rsp_last,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [6:0]         csr_data,
   output int                 fail_count,
   output int                 words_due
);

   localparam int N = apsp_pkg::NODES_DEF;
   localparam longint DIST_MAX = (longint'(1) <<< (apsp_pkg::DIST_BITS_DEF - 1)) - 1;
   localparam longint DIST_MIN = -DIST_MAX - 1;

   typedef struct {
      logic [1:0]         status;
      logic signed [47:0] distance;
      logic [5:0]         next_node;
      logic [5:0]         path_node;
      logic               last;
   } rsp_word_type;

   rsp_word_type due_q[$];

   longint     edge_weight [N*N];
   bit         edge_present[N*N];
   longint     dist_tab    [N*N];
   logic [1:0] cls_tab     [N*N];
   int         hop_tab     [N*N];
   logic [6:0] node_cnt;
   bit         computed;

   assign words_due = due_q.size();

   function automatic longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > DIST_MAX) return DIST_MAX;
      if (s < DIST_MIN) return DIST_MIN;
      return s;
   endfunction

   function automatic int live_nodes();
      if (node_cnt == 0) return 1;
      if (node_cnt > N) return N;
      return int'(node_cnt);
   endfunction

   task automatic push_word(logic [1:0] st, longint d, int nx, int pn, bit lst);
      rsp_word_type w;
      w.status    = st;
      w.distance  = d[47:0];
      w.next_node = nx[5:0];
      w.path_node = pn[5:0];
      w.last      = lst;
      due_q.insert(due_q.size(), w);
   endtask

   // min-plus closure, then the sweep that flags pairs touched by a negative cycle
   task automatic solve_tables(int n);
      int     ik, kj, ij;
      longint s;
      bit     better;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            ij = i*N + j;
            cls_tab[ij]  = edge_present[ij] ? apsp_pkg::CLS_FIN : apsp_pkg::CLS_NONE;
            dist_tab[ij] = edge_present[ij] ? edge_weight[ij] : 0;
            hop_tab[ij]  = j;
         end
      end
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               ik = i*N + k; kj = k*N + j; ij = i*N + j;
               if (cls_tab[ik] == apsp_pkg::CLS_FIN && cls_tab[kj] == apsp_pkg::CLS_FIN) begin
                  s = sat_sum(dist_tab[ik], dist_tab[kj]);
                  if (cls_tab[ij] == apsp_pkg::CLS_NONE || s < dist_tab[ij]) begin
                     dist_tab[ij] = s;
                     cls_tab[ij]  = apsp_pkg::CLS_FIN;
                     hop_tab[ij]  = hop_tab[ik];
                  end
               end
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               ik = i*N + k; kj = k*N + j; ij = i*N + j;
               if (cls_tab[ik] != apsp_pkg::CLS_NONE && cls_tab[kj] != apsp_pkg::CLS_NONE &&
                   cls_tab[ij] != apsp_pkg::CLS_NEG) begin
                  if (cls_tab[ik] == apsp_pkg::CLS_NEG || cls_tab[kj] == apsp_pkg::CLS_NEG)
                     better = 1;
                  else if (cls_tab[ij] == apsp_pkg::CLS_NONE)
                     better = 1;
                  else
                     better = sat_sum(dist_tab[ik], dist_tab[kj]) < dist_tab[ij];
                  if (better) begin
                     cls_tab[ij]  = apsp_pkg::CLS_NEG;
                     dist_tab[ij] = 0;
                     hop_tab[ij]  = 0;
                  end
               end
            end
         end
      end
   endtask

   task automatic predict_words(logic [1:0] mode, int r, int c, longint w, bit e);
      int  n, x, y, cur, cnt;
      int  walk[N];
      bit  stop;
      n = live_nodes();
      if (mode == apsp_pkg::MODE_LOAD) begin
         computed = 0;
         if (r < N && c < N) begin
            edge_weight[r*N + c]  = w;
            edge_present[r*N + c] = e;
         end
      end else if (mode == apsp_pkg::MODE_RUN) begin
         solve_tables(n);
         computed = 1;
         push_word(apsp_pkg::ST_DONE, 0, 0, 0, 1);
      end else if (!computed || r >= n || c >= n) begin
         push_word(apsp_pkg::CLS_NONE, 0, 0, 0, 1);
      end else begin
         x = r*N + c;
         if (cls_tab[x] != apsp_pkg::CLS_FIN) begin
            push_word(cls_tab[x], 0, 0, 0, 1);
         end else if (mode == apsp_pkg::MODE_PAIR) begin
            push_word(apsp_pkg::CLS_FIN, dist_tab[x], hop_tab[x], 0, 1);
         end else begin
            cur = r; cnt = 0; stop = 0;
            while (cur != c && !stop) begin
               y = cur*N + c;
               if (cls_tab[y] != apsp_pkg::CLS_FIN || cnt >= n - 1) begin
                  push_word(cls_tab[y] == apsp_pkg::CLS_NONE ? apsp_pkg::CLS_NONE
                                                             : apsp_pkg::CLS_NEG,
                            0, 0, 0, 1);
                  stop = 1;
               end else begin
                  walk[cnt] = cur;
                  cnt++;
                  cur = hop_tab[y];
                  if (cur >= n) begin
                     push_word(apsp_pkg::CLS_NEG, 0, 0, 0, 1);
                     stop = 1;
                  end
               end
            end
            if (!stop) begin
               if (cls_tab[c*N + c] == apsp_pkg::CLS_NEG) begin
                  push_word(apsp_pkg::CLS_NEG, 0, 0, 0, 1);
               end else begin
                  walk[cnt] = c;
                  cnt++;
                  for (int k = 0; k < cnt; k++)
                     push_word(apsp_pkg::CLS_FIN, dist_tab[x], hop_tab[x], walk[k],
                               k + 1 == cnt);
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         node_cnt   = apsp_pkg::NODE_COUNT_RESET;
         computed   = 0;
         fail_count = 0;
         due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            node_cnt = csr_data;
            computed = 0;
         end
         if (req_valid && !req_stall)
            predict_words(req_mode, int'(req_row), int'(req_col), longint'(req_weight),
                          req_has_edge);
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word status %0d distance %0d path_node %0d",
                        $time, rsp_status, rsp_distance, rsp_path_node);
            end else begin
               w = due_q.pop_front();
               if (rsp_status !== w.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d", $time, w.status, rsp_status);
               end
               if (rsp_distance !== w.distance) begin
                  fail_count++;
                  $display("%0t: distance expected %0d actual %0d",
                           $time, w.distance, rsp_distance);
               end
               if (rsp_next_node !== w.next_node) begin
                  fail_count++;
                  $display("%0t: next_node expected %0d actual %0d",
                           $time, w.next_node, rsp_next_node);
               end
               if (rsp_path_node !== w.path_node) begin
                  fail_count++;
                  $display("%0t: path_node expected %0d actual %0d",
                           $time, w.path_node, rsp_path_node);
               end
               if (rsp_last !== w.last) begin
                  fail_count++;
                  $display("%0t: last expected %0d actual %0d", $time, w.last, rsp_last);
               end
            end
         end
      end
   end

endmodule

[dv/tb_all_pairs_shortest_path_top.sv]
// stimulus, idling, watchdog and verdict for the all-pairs shortest path block
module tb_all_pairs_shortest_path_top;

   // cycles with no word moving on any channel before the run is abandoned
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int N = apsp_pkg::NODES_DEF;
   // nodes whose adjacency entries are all loaded early, so later runs stay legal
   localparam int FILL_NODES = 8;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_mode;
   logic [5:0]         req_row;
   logic [5:0]         req_col;
   logic signed [31:0] req_weight;
   logic               req_has_edge;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [47:0] rsp_distance;
   logic [5:0]         rsp_next_node;
   logic [5:0]         rsp_path_node;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [6:0]         csr_data;

   int fail_count;
   int words_due;
   int quiet_cycles;
   int random_items;
   bit calm;        // no idling on either side
   bit hold_rsp;    // ask the receiver for one long hold-off

   all_pairs_shortest_path_top dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_row, .req_col, .req_weight, .req_has_edge,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_distance, .rsp_next_node,
      .rsp_path_node, .rsp_last,
      .csr_valid, .csr_ready, .csr_data
   );

   all_pairs_shortest_path_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_row, .req_col, .req_weight, .req_has_edge,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_distance, .rsp_next_node,
      .rsp_path_node, .rsp_last,
      .csr_valid, .csr_ready, .csr_data,
      .fail_count, .words_due
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog: any accepted word on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int burst;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
            rsp_stall <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // drive one word, keep it steady until accepted
   task automatic send_word(logic [1:0] mode, int r, int c, logic [31:0] w, bit e);
      @(negedge clock);
      req_valid    <= 1;
      req_mode     <= mode;
      req_row      <= r[5:0];
      req_col      <= c[5:0];
      req_weight   <= w;
      req_has_edge <= e;
      do @(posedge clock); while (req_stall);
   endtask

   // sender gap, sometimes
   task automatic maybe_gap();
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic item(logic [1:0] mode, int r, int c, logic [31:0] w, bit e);
      maybe_gap();
      send_word(mode, r, c, w, e);
   endtask

   // node count written only once the block has drained
   task automatic set_node_count(logic [6:0] v);
      @(negedge clock);
      req_valid <= 0;
      while (words_due != 0) @(negedge clock);
      repeat (10) @(negedge clock);   // a trailing load may still be in flight
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 12)) - 12);
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   function automatic logic [6:0] pick_count();
      case ($urandom_range(0, 11))
         0: return 7'd0;
         1: return 7'(FILL_NODES);
         default: return 7'($urandom_range(1, 6));
      endcase
   endfunction

   initial begin
      int n, r, c, loads, asks, holds;
      logic [6:0] cnt;
      reset        = 1;
      req_valid    = 0;
      req_mode     = apsp_pkg::MODE_LOAD;
      req_row      = 0;
      req_col      = 0;
      req_weight   = 0;
      req_has_edge = 0;
      csr_valid    = 0;
      csr_data     = 0;
      calm         = 0;
      hold_rsp     = 0;
      random_items = 0;
      holds        = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // queries before any run: no path
      item(apsp_pkg::MODE_PAIR, 0, 0, 0, 0);
      item(apsp_pkg::MODE_PATH, 63, 63, 0, 0);
      // out of range load is ignored
      item(apsp_pkg::MODE_LOAD, 63, 5, 32'h7fff_ffff, 1);
      item(apsp_pkg::MODE_LOAD, 2, 40, 32'h8000_0000, 1);

      // node count zero acts as one: single self loop, negative
      set_node_count(7'd0);
      item(apsp_pkg::MODE_LOAD, 0, 0, 32'h8000_0000, 1);
      item(apsp_pkg::MODE_RUN, 0, 0, 0, 0);
      item(apsp_pkg::MODE_PAIR, 0, 0, 0, 0);
      item(apsp_pkg::MODE_PATH, 0, 0, 0, 0);
      item(apsp_pkg::MODE_PAIR, 1, 0, 0, 0);   // row beyond the nodes in use

      // three nodes: 0->1->2 chain with a detour, extreme weights
      set_node_count(7'd3);
      item(apsp_pkg::MODE_LOAD, 0, 0, 0, 1);
      item(apsp_pkg::MODE_LOAD, 0, 1, 5, 1);
      item(apsp_pkg::MODE_LOAD, 0, 2, 32'h7fff_ffff, 1);
      item(apsp_pkg::MODE_LOAD, 1, 0, 0, 0);
      item(apsp_pkg::MODE_LOAD, 1, 1, 0, 0);
      item(apsp_pkg::MODE_LOAD, 1, 2, 32'hffff_fffd, 1);
      item(apsp_pkg::MODE_LOAD, 2, 0, 32'h7fff_ffff, 1);
      item(apsp_pkg::MODE_LOAD, 2, 1, 0, 0);
      item(apsp_pkg::MODE_LOAD, 2, 2, 0, 1);
      item(apsp_pkg::MODE_PAIR, 0, 2, 0, 0);   // load cleared the result
      item(apsp_pkg::MODE_RUN, 0, 0, 0, 0);
      item(apsp_pkg::MODE_PATH, 0, 2, 0, 0);
      item(apsp_pkg::MODE_PATH, 1, 0, 0, 0);
      item(apsp_pkg::MODE_PAIR, 2, 1, 0, 0);
      item(apsp_pkg::MODE_PATH, 2, 2, 0, 0);

      // fill the upper corner of the adjacency store so any later run is legal
      set_node_count(7'(FILL_NODES));
      for (int i = 0; i < FILL_NODES; i++) begin
         for (int j = 0; j < FILL_NODES; j++)
            item(apsp_pkg::MODE_LOAD, i, j, pick_weight(), $urandom_range(0, 9) < 3);
      end
      item(apsp_pkg::MODE_RUN, 0, 0, 0, 0);
      for (int q = 0; q < 6; q++)
         item($urandom_range(0, 1) ? apsp_pkg::MODE_PAIR : apsp_pkg::MODE_PATH,
              $urandom_range(0, 15), $urandom_range(0, 15), 0, 0);

      // random rounds: reload part of the graph, run, then query
      while (random_items < 50) begin
         if (random_items > 35) calm = 1;
         cnt = pick_count();
         set_node_count(cnt);
         n = (cnt == 0) ? 1 : (cnt > N) ? N : int'(cnt);
         // rebuild a small graph with a sparse pattern so paths exist
         loads = (n <= 4) ? n * n : $urandom_range(4, 12);
         for (int l = 0; l < loads; l++) begin
            if (n <= 4) begin
               r = l / n; c = l % n;
            end else begin
               r = $urandom_range(0, n - 1); c = $urandom_range(0, n - 1);
            end
            item(apsp_pkg::MODE_LOAD, r, c, pick_weight(), $urandom_range(0, 2) != 0);
            random_items++;
         end
         if ($urandom_range(0, 3) == 0) begin
            item(apsp_pkg::MODE_LOAD, $urandom_range(16, 63), $urandom_range(0, 63),
                 $urandom, 1);
            random_items++;
         end
         item(apsp_pkg::MODE_RUN, 0, 0, 0, 0);
         random_items++;
         if (holds == 0 || (random_items < 30 && $urandom_range(0, 2) == 0)) begin
            hold_rsp = 1;
            holds++;
         end
         asks = $urandom_range(4, 10);
         for (int q = 0; q < asks; q++) begin
            if ($urandom_range(0, 7) == 0) begin
               r = $urandom_range(0, 63); c = $urandom_range(0, 63);
            end else begin
               r = $urandom_range(0, n - 1); c = $urandom_range(0, n - 1);
            end
            if ($urandom_range(0, 15) == 0)
               item(apsp_pkg::MODE_LOAD, r, c, pick_weight(), $urandom_range(0, 1));
            else
               item($urandom_range(0, 2) == 0 ? apsp_pkg::MODE_PAIR : apsp_pkg::MODE_PATH,
                    r, c, 0, 0);
            random_items++;
         end
      end

      // drain and settle
      @(negedge clock);
      req_valid <= 0;
      while (words_due != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
